[sv/spectrum_cosine_similarity_defines.svh]
// ----------------------------------------------------------------------------
// spectrum cosine similarity assertion macros
// shared property macros for the spectrum cosine similarity block
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_COSINE_SIMILARITY_DEFINES_SVH
`define SPECTRUM_COSINE_SIMILARITY_DEFINES_SVH

// same-cycle implication
`define SCS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scs assertion failed");

// next-cycle implication
`define SCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scs assertion failed");

`endif

[sv/scs_pkg.sv]
// ----------------------------------------------------------------------------
// scs_pkg
// types and constants of the spectrum cosine similarity block
// ----------------------------------------------------------------------------
package scs_pkg;

   localparam int MAX_PEAKS_DEF = 256;
   localparam int MZ_W          = 26;
   localparam int INT_W         = 24;
   localparam int TOL_W         = 20;
   localparam int SIM_W         = 17;
   localparam int CMD_W         = 2;
   localparam int PEAK_W        = MZ_W + INT_W;
   localparam int PPROD_W       = 2 * INT_W;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(100);
   localparam logic [SIM_W-1:0] SIM_ONE   = SIM_W'(65536);

   localparam logic [CMD_W-1:0] CMD_FIRST   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SECOND  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [MZ_W-1:0]  mz;
      logic [INT_W-1:0] intensity;
   } req_type;

   typedef struct packed {
      logic [SIM_W-1:0] similarity;
      logic             status;
   } rsp_type;

endpackage

[sv/scs_math.sv]
// ----------------------------------------------------------------------------
// scs_math
// multi-cycle unit: floor(65536 * dot / sqrt(mag1 * mag2)) via shift-add
// multiplies, restoring division and a digit-by-digit square root
// ----------------------------------------------------------------------------
module scs_math #(
   parameter int ACC_W = 56
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ACC_W-1:0]          dot,
   input  logic [ACC_W-1:0]          mag1,
   input  logic [ACC_W-1:0]          mag2,
   output logic                      done,
   output logic [scs_pkg::SIM_W-1:0] sim
);
   import scs_pkg::*;

   localparam int PROD_W = 2 * ACC_W;
   localparam int REM_W  = PROD_W + 32;
   localparam int Q_W    = 33;
   localparam int CNT_W  = $clog2(ACC_W + 1);

   localparam logic [2:0] M_IDLE  = 3'd0;
   localparam logic [2:0] M_MUL1  = 3'd1;
   localparam logic [2:0] M_LOAD2 = 3'd2;
   localparam logic [2:0] M_MUL2  = 3'd3;
   localparam logic [2:0] M_LOADD = 3'd4;
   localparam logic [2:0] M_DIV   = 3'd5;
   localparam logic [2:0] M_SQRT  = 3'd6;
   localparam logic [2:0] M_DONE  = 3'd7;

   logic [2:0]        state_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [PROD_W-1:0] mcand_ff;
   logic [ACC_W-1:0]  mplier_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]  dot_ff;
   logic [REM_W-1:0]  dvs_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [Q_W-1:0]    q_ff;
   logic [SIM_W-1:0]  root_ff;
   logic [SIM_W-1:0]  bit_ff;

   logic [PROD_W-1:0]  prod_in;
   logic [SIM_W-1:0]   trial;
   logic [2*SIM_W-1:0] trial_sq;

   assign prod_in  = mplier_ff[0] ? prod_ff + mcand_ff : prod_ff;
   assign trial    = root_ff | bit_ff;
   assign trial_sq = (2*SIM_W)'(trial) * (2*SIM_W)'(trial);
   assign done     = (state_ff == M_DONE);
   assign sim      = root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         case (state_ff)
            M_IDLE: begin
               if (start) begin
                  dot_ff <= dot;
                  if (mag1 == '0 || mag2 == '0) begin
                     root_ff  <= '0;
                     state_ff <= M_DONE;
                  end else begin
                     mcand_ff  <= PROD_W'(mag1);
                     mplier_ff <= mag2;
                     prod_ff   <= '0;
                     cnt_ff    <= CNT_W'(ACC_W);
                     state_ff  <= M_MUL1;
                  end
               end
            end
            M_MUL1, M_MUL2: begin
               prod_ff   <= prod_in;
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
               cnt_ff    <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= (state_ff == M_MUL1) ? M_LOAD2 : M_LOADD;
               end
            end
            M_LOAD2: begin
               dvs_ff    <= {prod_ff, 32'b0};
               mcand_ff  <= PROD_W'(dot_ff);
               mplier_ff <= dot_ff;
               prod_ff   <= '0;
               cnt_ff    <= CNT_W'(ACC_W);
               state_ff  <= M_MUL2;
            end
            M_LOADD: begin
               rem_ff   <= {prod_ff, 32'b0};
               q_ff     <= '0;
               cnt_ff   <= CNT_W'(Q_W);
               state_ff <= M_DIV;
            end
            M_DIV: begin
               if (rem_ff >= dvs_ff) begin
                  rem_ff <= rem_ff - dvs_ff;
                  q_ff   <= {q_ff[Q_W-2:0], 1'b1};
               end else begin
                  q_ff   <= {q_ff[Q_W-2:0], 1'b0};
               end
               dvs_ff <= dvs_ff >> 1;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  root_ff  <= '0;
                  bit_ff   <= SIM_W'(1) << (SIM_W - 1);
                  state_ff <= M_SQRT;
               end
            end
            M_SQRT: begin
               if (trial_sq <= (2*SIM_W)'(q_ff)) begin
                  root_ff <= trial;
               end
               bit_ff <= bit_ff >> 1;
               if (bit_ff[0]) begin
                  state_ff <= M_DONE;
               end
            end
            M_DONE: begin
               state_ff <= M_IDLE;
            end
            default: begin
               state_ff <= M_IDLE;
            end
         endcase
      end
   end

endmodule

[sv/spectrum_cosine_similarity.sv]
// ----------------------------------------------------------------------------
// spectrum_cosine_similarity
// cosine similarity of two peak lists held in on-chip peak memories
// ----------------------------------------------------------------------------
// channel   ports                        direction  handshake
// request   start, busy, req_item        in         start high and busy low
// result    rsp_valid, rsp_item          out        one-cycle strobe
// config    csr_wr_en, csr_wr_data       in         write enable
//
// a peak load is written into its memory when accepted; the next item can follow at once
// compute with n1 first and n2 second peaks first runs the match scan over all
// n1 first peaks for each second peak (one first-peak memory read per cycle),
// then the serial multiply, divide and square root unit
// busy stays high for the whole compute; an empty spectrum answers at once
// reset is synchronous; counts and tolerance reset, peak memories do not
// ----------------------------------------------------------------------------
`include "spectrum_cosine_similarity_defines.svh"

module spectrum_cosine_similarity #(
   parameter int MAX_PEAKS = scs_pkg::MAX_PEAKS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  scs_pkg::req_type          req_item,
   output logic                      rsp_valid,
   output scs_pkg::rsp_type          rsp_item,
   input  logic                      csr_wr_en,
   input  logic [scs_pkg::TOL_W-1:0] csr_wr_data
);
   import scs_pkg::*;

   localparam int CNT_W  = $clog2(MAX_PEAKS + 1);
   localparam int ADDR_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
   localparam int ACC_W  = PPROD_W + $clog2(MAX_PEAKS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ROW  = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_MULT = 3'd3;
   localparam logic [2:0] ST_ACC  = 3'd4;
   localparam logic [2:0] ST_MATH = 3'd5;

   logic [PEAK_W-1:0] first_mem  [MAX_PEAKS];
   logic [PEAK_W-1:0] second_mem [MAX_PEAKS];

   logic [2:0]         state_ff;
   logic [CNT_W-1:0]   first_count_ff;
   logic [CNT_W-1:0]   second_count_ff;
   logic [CNT_W-1:0]   j_ff;
   logic [CNT_W-1:0]   k_ff;
   logic [TOL_W-1:0]   tol_ff;
   logic [PEAK_W-1:0]  first_rd_ff;
   logic [PEAK_W-1:0]  second_rd_ff;
   logic [INT_W-1:0]   best_ff;
   logic [PPROD_W-1:0] p_dot_ff;
   logic [PPROD_W-1:0] p_m1_ff;
   logic [PPROD_W-1:0] p_m2_ff;
   logic [ACC_W-1:0]   dot_ff;
   logic [ACC_W-1:0]   mag1_ff;
   logic [ACC_W-1:0]   mag2_ff;
   logic               math_start_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               accept;
   logic               first_we;
   logic               second_we;
   logic               first_re;
   logic               second_re;
   logic [ADDR_W-1:0]  first_raddr;
   logic [MZ_W-1:0]    m1;
   logic [MZ_W-1:0]    m2;
   logic [INT_W-1:0]   i1;
   logic [INT_W-1:0]   i2;
   logic [MZ_W-1:0]    mz_diff;
   logic               match;
   logic [INT_W-1:0]   best_in;
   logic [CNT_W-1:0]   j_next;
   logic               math_done;
   logic [SIM_W-1:0]   math_sim;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign first_we  = accept && req_item.cmd == CMD_FIRST
                      && first_count_ff < CNT_W'(MAX_PEAKS);
   assign second_we = accept && req_item.cmd == CMD_SECOND
                      && second_count_ff < CNT_W'(MAX_PEAKS);

   assign first_re    = (state_ff == ST_ROW)
                        || (state_ff == ST_SCAN && k_ff < first_count_ff);
   assign first_raddr = (state_ff == ST_ROW) ? '0 : k_ff[ADDR_W-1:0];
   assign second_re   = (state_ff == ST_ROW);

   assign m1      = first_rd_ff[PEAK_W-1:INT_W];
   assign i1      = first_rd_ff[INT_W-1:0];
   assign m2      = second_rd_ff[PEAK_W-1:INT_W];
   assign i2      = second_rd_ff[INT_W-1:0];
   assign mz_diff = (m1 >= m2) ? m1 - m2 : m2 - m1;
   assign match   = mz_diff <= MZ_W'(tol_ff);
   assign best_in = (match && i1 > best_ff) ? i1 : best_ff;
   assign j_next  = j_ff + 1'b1;

   // peak memories
   always_ff @(posedge clock) begin
      if (first_we) begin
         first_mem[first_count_ff[ADDR_W-1:0]] <= {req_item.mz, req_item.intensity};
      end
      if (first_re) begin
         first_rd_ff <= first_mem[first_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (second_we) begin
         second_mem[second_count_ff[ADDR_W-1:0]] <= {req_item.mz, req_item.intensity};
      end
      if (second_re) begin
         second_rd_ff <= second_mem[j_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         math_start_ff   <= 1'b0;
      end else begin
         rsp_valid_ff  <= 1'b0;
         math_start_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (first_we) begin
                  first_count_ff <= first_count_ff + 1'b1;
               end
               if (second_we) begin
                  second_count_ff <= second_count_ff + 1'b1;
               end
               if (accept && req_item.cmd == CMD_COMPUTE) begin
                  if (first_count_ff == '0 || second_count_ff == '0) begin
                     rsp_valid_ff      <= 1'b1;
                     rsp_ff.similarity <= '0;
                     rsp_ff.status     <= 1'b1;
                     first_count_ff    <= '0;
                     second_count_ff   <= '0;
                  end else begin
                     j_ff     <= '0;
                     dot_ff   <= '0;
                     mag1_ff  <= '0;
                     mag2_ff  <= '0;
                     state_ff <= ST_ROW;
                  end
               end
            end
            ST_ROW: begin
               k_ff     <= CNT_W'(1);
               best_ff  <= '0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               best_ff <= best_in;
               if (k_ff < first_count_ff) begin
                  k_ff <= k_ff + 1'b1;
               end else begin
                  state_ff <= ST_MULT;
               end
            end
            ST_MULT: begin
               p_dot_ff <= PPROD_W'(best_ff) * PPROD_W'(i2);
               p_m1_ff  <= PPROD_W'(best_ff) * PPROD_W'(best_ff);
               p_m2_ff  <= PPROD_W'(i2) * PPROD_W'(i2);
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               dot_ff  <= dot_ff + ACC_W'(p_dot_ff);
               mag1_ff <= mag1_ff + ACC_W'(p_m1_ff);
               mag2_ff <= mag2_ff + ACC_W'(p_m2_ff);
               j_ff    <= j_next;
               if (j_next == second_count_ff) begin
                  math_start_ff <= 1'b1;
                  state_ff      <= ST_MATH;
               end else begin
                  state_ff <= ST_ROW;
               end
            end
            ST_MATH: begin
               if (math_done) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_ff.similarity <= math_sim;
                  rsp_ff.status     <= 1'b0;
                  first_count_ff    <= '0;
                  second_count_ff   <= '0;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   scs_math #(
      .ACC_W (ACC_W)
   ) u_math (
      .clock (clock),
      .reset (reset),
      .start (math_start_ff),
      .dot   (dot_ff),
      .mag1  (mag1_ff),
      .mag2  (mag2_ff),
      .done  (math_done),
      .sim   (math_sim)
   );

   `SCS_ASSERT_IMP(a_status_zero_sim, clock, reset, rsp_valid && rsp_item.status, rsp_item.similarity == '0)
   `SCS_ASSERT_IMP(a_sim_range, clock, reset, rsp_valid, rsp_item.similarity <= SIM_ONE)
   `SCS_ASSERT_IMP(a_scan_bound, clock, reset, state_ff == ST_SCAN, k_ff <= first_count_ff && k_ff != '0)
   `SCS_ASSERT_NEXT(a_compute_clears, clock, reset, accept && req_item.cmd == CMD_COMPUTE, busy || (first_count_ff == '0 && second_count_ff == '0))

endmodule
